// ===== rtl/core/round_robin_request_table_macros.svh =====
// assertion macros for the round robin request table checker
// no dependencies; included by files that carry concurrent assertions
`ifndef ROUND_ROBIN_REQUEST_TABLE_MACROS_SVH
`define ROUND_ROBIN_REQUEST_TABLE_MACROS_SVH

// generic clocked assertion with asynchronous active-low reset
`define RRRT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the default clock and reset
`define RRRT_ASSERT(lbl, prop, msg) \
  `RRRT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/rrrt_pkg.sv =====
// types, codes and constants for the round robin request table
// no dependencies; imported by every module of the block
package rrrt_pkg;

  localparam int unsigned ENTRIES_DEF   = 10;
  localparam int unsigned MAX_HOLES_DEF = 32;

  localparam int unsigned CNT_W  = 4;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CALL_W = 64;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned OFS_W  = 32;
  localparam int unsigned HOLE_W = 6;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ACT_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SERVE  = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_CLOSED = 3'd2,
    ST_BADPOS = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [CALL_W-1:0] callsign;
    logic              request_type;
    logic [ID_W-1:0]   file_id;
    logic [OFS_W-1:0]  start_offset;
    logic [HOLE_W-1:0] hole_count;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              served_valid;
    logic [CALL_W-1:0] served_callsign;
    logic              served_type;
    logic [ID_W-1:0]   served_file_id;
    logic [OFS_W-1:0]  served_offset;
    logic [HOLE_W-1:0] served_hole_count;
    logic [HOLE_W-1:0] served_hole_position;
    logic [CNT_W-1:0]  entries_in_use;
    logic [CNT_W-1:0]  next_serve_index;
    logic              list_full;
  } out_item_t;

  typedef struct packed {
    logic [CALL_W-1:0] callsign;
    logic              rtype;
    logic [ID_W-1:0]   file_id;
    logic [OFS_W-1:0]  offset;
    logic [HOLE_W-1:0] hole_count;
    logic [HOLE_W-1:0] hole_position;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_pending;
  } ctrl_sts_t;

endpackage

// ===== rtl/core/rrrt_ctrl.sv =====
// controller state machine: captures an item, then runs it once the output is free
// depends on rrrt_pkg
module rrrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rrrt_pkg::ctrl_sts_t sts_i,
  output rrrt_pkg::ctrl_cmd_t cmd_o
);
  import rrrt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (!sts_i.out_pending) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      CS_EXEC: begin
        cmd_o.execute = !sts_i.out_pending;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/rrrt_table.sv =====
// datapath: shift-register request table, count, serve pointer and output register
// depends on rrrt_pkg
module rrrt_table #(
  parameter int unsigned ENTRIES   = rrrt_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_HOLES = rrrt_pkg::MAX_HOLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  rrrt_pkg::in_item_t  in_item_i,
  output rrrt_pkg::out_item_t out_item_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rrrt_pkg::ctrl_cmd_t cmd_i,
  output rrrt_pkg::ctrl_sts_t sts_o
);
  import rrrt_pkg::*;

  localparam logic [CNT_W-1:0]  FullCnt  = CNT_W'(ENTRIES - 1);
  localparam logic [HOLE_W-1:0] HoleMax  = HOLE_W'(MAX_HOLES);

  in_item_t         in_q;
  logic             closed_q;
  entry_t           slots_q [ENTRIES];
  entry_t           slots_d [ENTRIES];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] sel;
  logic [CNT_W-1:0] sel_inc;
  out_item_t        out_q, out_d;
  logic             out_valid_q;
  entry_t           new_entry;
  entry_t           served;
  logic             served_vld;
  status_e          status;

  always_comb begin
    new_entry.callsign      = in_q.callsign;
    new_entry.rtype         = in_q.request_type;
    new_entry.file_id       = in_q.file_id;
    new_entry.offset        = in_q.start_offset;
    new_entry.hole_count    = (in_q.hole_count > HoleMax) ? HoleMax : in_q.hole_count;
    new_entry.hole_position = '0;
  end

  assign sel     = (ptr_q >= count_q) ? '0 : ptr_q;
  assign sel_inc = sel + CNT_W'(1);

  always_comb begin
    slots_d    = slots_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    status     = ST_OK;
    served     = '0;
    served_vld = 1'b0;
    case (action_e'(in_q.action))
      ACT_ADD: begin
        if (closed_q) begin
          status = ST_CLOSED;
        end else if (count_q >= FullCnt) begin
          status = ST_FULL;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (count_q == CNT_W'(i)) begin
              slots_d[i] = new_entry;
            end
          end
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (in_q.position >= count_q) begin
          status = ST_BADPOS;
        end else begin
          for (int i = 0; i < ENTRIES - 1; i++) begin
            if (CNT_W'(i) >= in_q.position) begin
              slots_d[i] = slots_q[i+1];
            end
          end
          count_d = count_q - CNT_W'(1);
          if (in_q.position <= ptr_q && ptr_q != '0) begin
            ptr_d = ptr_q - CNT_W'(1);
          end
        end
      end
      ACT_SERVE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (sel == CNT_W'(i)) begin
              served = slots_q[i];
            end
          end
          served_vld = 1'b1;
          ptr_d      = (sel_inc >= count_q) ? '0 : sel_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.status               = status;
    out_d.served_valid         = served_vld;
    out_d.served_callsign      = served.callsign;
    out_d.served_type          = served.rtype;
    out_d.served_file_id       = served.file_id;
    out_d.served_offset        = served.offset;
    out_d.served_hole_count    = served.hole_count;
    out_d.served_hole_position = served.hole_position;
    out_d.entries_in_use       = count_d;
    out_d.next_serve_index     = ptr_d;
    out_d.list_full            = (count_d == FullCnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q    <= 1'b0;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        closed_q <= cfg_wdata_i;
      end
      if (cmd_i.execute) begin
        count_q     <= count_d;
        ptr_q       <= ptr_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_item_i;
    end
    if (cmd_i.execute) begin
      slots_q <= slots_d;
      out_q   <= out_d;
    end
  end

  assign sts_o.out_pending = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

// ===== rtl/core/round_robin_request_table.sv =====
// top level of the round robin request table
// depends on rrrt_pkg, rrrt_ctrl and rrrt_table
//
// Request table served round robin, holding up to ENTRIES-1 requests. Each
// item is an add, a remove at a position, or a serve, and produces exactly one
// result item. An item is first captured into the input register; then the
// controller runs it on the table, which updates the whole shift-register
// table, count and serve pointer at once. A new item is taken only after the
// last one has run; the result waits in the output register, so the next item
// is captured while it is unread, and it runs only once that register is free.
// The closed register is written through cfg_we_i and cfg_wdata_i.
module round_robin_request_table #(
  parameter int unsigned ENTRIES   = rrrt_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_HOLES = rrrt_pkg::MAX_HOLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrrt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rrrt_pkg::out_item_t out_item_o
);
  import rrrt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rrrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrrt_table #(
    .ENTRIES   (ENTRIES),
    .MAX_HOLES (MAX_HOLES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== rtl/core/rrrt_checker.sv =====
// port-level assertions for the round robin request table, bound to the top level
// depends on rrrt_pkg and round_robin_request_table_macros.svh
`include "round_robin_request_table_macros.svh"

module rrrt_checker #(
  parameter int unsigned ENTRIES = rrrt_pkg::ENTRIES_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input rrrt_pkg::out_item_t out_item_i
);
  import rrrt_pkg::*;

  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(ENTRIES - 1);

  `RRRT_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i), "result changed while stalled")
  `RRRT_ASSERT(a_count_range, out_valid_i |-> out_item_i.entries_in_use <= FullCnt, "count above capacity")
  `RRRT_ASSERT(a_full_flag, out_valid_i |-> out_item_i.list_full == (out_item_i.entries_in_use == FullCnt), "full flag disagrees with count")
  `RRRT_ASSERT(a_served_ok, out_valid_i && out_item_i.served_valid |-> out_item_i.status == ST_OK, "served entry with error status")
  `RRRT_ASSERT(a_ptr_range, out_valid_i |-> out_item_i.next_serve_index < out_item_i.entries_in_use || out_item_i.next_serve_index == '0, "serve pointer outside table")

endmodule

bind round_robin_request_table rrrt_checker #(
  .ENTRIES (ENTRIES)
) u_rrrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);
